/* src/bcf_pkg.sv */
// shared types and constants of the bezier curve flattener
`default_nettype none

package bcf_pkg;

    localparam int COORD_W  = 16;
    localparam int T_FRAC   = 16;
    localparam int T_W      = T_FRAC + 1;
    localparam int STEP_W   = 6;
    localparam int PROD_W   = COORD_W + T_W + 1;

    localparam logic [T_W-1:0]    T_ONE       = T_W'(1) << T_FRAC;
    localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(10);

    localparam logic REQ_QUAD  = 1'b0;
    localparam logic REQ_CUBIC = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] pt0_x;
        logic signed [COORD_W-1:0] pt0_y;
        logic signed [COORD_W-1:0] pt1_x;
        logic signed [COORD_W-1:0] pt1_y;
        logic signed [COORD_W-1:0] pt2_x;
        logic signed [COORD_W-1:0] pt2_y;
        logic signed [COORD_W-1:0] pt3_x;
        logic signed [COORD_W-1:0] pt3_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic                      last_segment;
    } t_out_item;

endpackage

`default_nettype wire

/* src/bezier_curve_flattener_core.sv */
// top level of the bezier curve flattener: sequencer around one shared multiplier
`default_nettype none

// Flattens one quadratic or cubic Bezier curve per input transaction into
// num_steps+1 line segments (num_steps of zero acts as one). Point i is taken
// at t = floor(i*65536/num_steps) by de Casteljau interpolation, truncating
// each interpolation by an arithmetic shift. The first segment is degenerate
// (pt0 to pt0) and the segment at t equal to one carries last_segment. The
// block handles one curve at a time and is not ready while it works. At the
// start of a curve a restoring divider forms the t step 65536/num_steps and
// its remainder; after that t advances by one add and compare per point.
// Every interpolation takes a 17x18 signed multiply state and an add state on
// the shared multiplier, and each axis adds a load state and a shift state
// per level, both axes in turn. Each segment then waits in the output state
// until the consumer takes it, and the next curve is accepted only after the
// last segment is taken. num_steps is written through i_cfg_we and
// i_cfg_wdata and must only change while the block is idle.
module bezier_curve_flattener_core
    import bcf_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [STEP_W-1:0] i_cfg_wdata,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output t_out_item        o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int DIV_CNT_W = $clog2(T_W);

    logic [2:0]              r_state;
    logic [STEP_W-1:0]       r_num_steps;   // configuration register
    logic [STEP_W-1:0]       r_n;           // step count in use, never zero
    logic                    r_kind;

    // control points per axis, each read at a fixed place
    logic signed [COORD_W-1:0] r_px [0:3];
    logic signed [COORD_W-1:0] r_py [0:3];

    // divider for the t increment
    logic [STEP_W:0]         r_div_rem;
    logic [T_W-1:0]          r_div_q;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    logic [T_W-1:0]          r_t_inc;
    logic [STEP_W-1:0]       r_t_inc_rem;

    // parameter walk
    logic [T_W-1:0]          r_t;
    logic [STEP_W-1:0]       r_t_acc;       // remainder of i*65536/N
    logic [STEP_W-1:0]       r_i;

    // de Casteljau work row: the pair w0, w1 feeds the multiplier
    logic signed [COORD_W-1:0] r_w [0:3];
    logic [1:0]              r_deg;         // interpolations in this level
    logic [1:0]              r_j;
    logic                    r_axis;
    logic signed [PROD_W-2:0] r_prod;

    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y;

    // combinational helpers
    logic                     div_bit;
    logic [STEP_W:0]          div_sh;
    logic                     div_ge;
    logic signed [COORD_W:0]  diff;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [COORD_W+1:0] lerp_sum;
    logic signed [COORD_W-1:0] lerp_res;
    logic [STEP_W:0]          acc_sum;
    logic                     acc_wrap;
    logic                     is_last;
    logic                     in_fire, out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign is_last  = (r_i == r_n);

    // one restoring division step per cycle, only bit T_FRAC of the dividend is set
    assign div_bit = (r_div_cnt == DIV_CNT_W'(T_FRAC));
    assign div_sh  = {r_div_rem[STEP_W-1:0], div_bit};
    assign div_ge  = (div_sh >= {1'b0, r_n});

    // the shared multiplier: (w1 - w0) * t
    assign diff      = {r_w[1][COORD_W-1], r_w[1]} - {r_w[0][COORD_W-1], r_w[0]};
    assign prod_full = diff * $signed({1'b0, r_t});

    // w0 + floor(prod / 2^T_FRAC), always back inside the coordinate range
    assign lerp_sum = {{2{r_w[0][COORD_W-1]}}, r_w[0]}
                    + {r_prod[PROD_W-2], r_prod[PROD_W-2:T_FRAC]};
    assign lerp_res = lerp_sum[COORD_W-1:0];

    // t step: remainder stays below N, so one compare and subtract
    assign acc_sum  = {1'b0, r_t_acc} + {1'b0, r_t_inc_rem};
    assign acc_wrap = (acc_sum >= {1'b0, r_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_steps <= STEPS_RESET;
        end else if (i_cfg_we) begin
            r_num_steps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= REQ_QUAD;
            r_i      <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_n      <= STEP_W'(1);
            r_t      <= '0;
            r_t_acc  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_kind    <= i_in.req_type;
                        r_px[0]   <= i_in.pt0_x;
                        r_px[1]   <= i_in.pt1_x;
                        r_px[2]   <= i_in.pt2_x;
                        r_px[3]   <= i_in.pt3_x;
                        r_py[0]   <= i_in.pt0_y;
                        r_py[1]   <= i_in.pt1_y;
                        r_py[2]   <= i_in.pt2_y;
                        r_py[3]   <= i_in.pt3_y;
                        r_prev_x  <= i_in.pt0_x;
                        r_prev_y  <= i_in.pt0_y;
                        r_n       <= (r_num_steps == '0) ? STEP_W'(1) : r_num_steps;
                        r_div_rem <= '0;
                        r_div_q   <= '0;
                        r_div_cnt <= DIV_CNT_W'(T_FRAC);
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_rem <= div_ge ? (div_sh - {1'b0, r_n}) : div_sh;
                    r_div_q   <= {r_div_q[T_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_t_inc     <= {r_div_q[T_W-2:0], div_ge};
                        r_t_inc_rem <= div_ge ? STEP_W'(div_sh - {1'b0, r_n})
                                              : STEP_W'(div_sh);
                        r_t       <= '0;
                        r_t_acc   <= '0;
                        r_i       <= '0;
                        r_axis    <= 1'b0;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int k = 0; k < 4; k++) begin
                        r_w[k] <= r_axis ? r_py[k] : r_px[k];
                    end
                    r_deg   <= (r_kind == REQ_CUBIC) ? 2'd3 : 2'd2;
                    r_j     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= prod_full[PROD_W-2:0];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // shift the row down and drop the result in behind this level
                    for (int k = 0; k < 3; k++) begin
                        r_w[k] <= (2'(k) == r_deg) ? lerp_res : r_w[k+1];
                    end
                    r_w[3] <= (r_deg == 2'd3) ? lerp_res : r_w[3];
                    if (r_j == r_deg - 2'd1) begin
                        r_j     <= '0;
                        r_state <= S_SHIFT;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_SHIFT: begin
                    // discard the leftover operand of the finished level
                    for (int k = 0; k < 3; k++) begin
                        r_w[k] <= r_w[k+1];
                    end
                    if (r_deg == 2'd1) begin
                        if (r_axis) begin
                            r_cur_y <= r_w[1];
                            r_state <= S_OUT;
                        end else begin
                            r_cur_x <= r_w[1];
                            r_axis  <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_deg   <= r_deg - 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (out_fire) begin
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + STEP_W'(1);
                            r_t_acc <= acc_wrap ? STEP_W'(acc_sum - {1'b0, r_n})
                                                : STEP_W'(acc_sum);
                            r_t     <= r_t + r_t_inc + T_W'(acc_wrap);
                            r_axis  <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = (r_state == S_OUT);
    assign o_out.from_x       = r_prev_x;
    assign o_out.from_y       = r_prev_y;
    assign o_out.to_x         = r_cur_x;
    assign o_out.to_y         = r_cur_y;
    assign o_out.last_segment = is_last;

    // t never runs past one
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t <= T_ONE)
        else $error("t beyond one");

    // remainder of the t walk stays below the step count while points are made
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_ADD || r_state == S_OUT) |-> r_t_acc < r_n)
        else $error("t remainder out of range");

    // the last point is exactly t equal to one
    a_last_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last_segment) |-> r_t == T_ONE)
        else $error("last segment not at t equal to one");

    // the step index never passes the step count
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DIV) |-> r_i <= r_n)
        else $error("step index past step count");

    // after the last segment is taken the block is ready for the next curve
    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last_segment) |=> o_in_ready)
        else $error("no return to idle after last segment");

endmodule

`default_nettype wire
